/* hdl/base64_encoder_unpadded_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the unpadded base64 encoder
// Shared helpers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_ENCODER_UNPADDED_CORE_DEFINES_SVH
`define BASE64_ENCODER_UNPADDED_CORE_DEFINES_SVH

// property checked only outside reset
`define B64U_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define B64U_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/b64u_pkg.sv */
// ----------------------------------------------------------------------------
// b64u_pkg
// Types, constants and the character map of the unpadded base64 encoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_char;
    logic       run_end;
    logic       message_end;
  } out_item_t;

  // one group of work for the back end
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  last_k;   // index of the last character to send (1..3)
    logic        fin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] char_of(input logic [5:0] idx);
    logic [7:0] v;
    v = {2'b00, idx};
    if (idx < 6'd10)      char_of = v + 8'd48;          // '0'..'9'
    else if (idx < 6'd36) char_of = v - 8'd10 + 8'd97;  // 'a'..'z'
    else if (idx < 6'd62) char_of = v - 8'd36 + 8'd65;  // 'A'..'Z'
    else if (idx == 6'd62) char_of = 8'd45;             // '-'
    else                  char_of = 8'd95;              // '_'
  endfunction

endpackage

/* hdl/b64u_front.sv */
// ----------------------------------------------------------------------------
// b64u_front
// Collects bytes into 24-bit groups and hands finished groups to the queue.
// ----------------------------------------------------------------------------
module b64u_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  b64u_pkg::in_item_t  in_item,
  output logic                in_full,
  input  b64u_pkg::q_status_t q_stat,
  output logic                q_push,
  output b64u_pkg::job_t      q_job
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  prior;
  logic [1:0]  n;
  logic        accept;
  logic        emit;

  always_comb begin
    prior   = (cnt_r == 2'd3) ? 2'd2 : cnt_r;
    n       = prior + 2'd1;
    accept  = in_push & ~q_stat.full;
    emit    = accept & ((n == 2'd3) | in_item.final_byte);
    q_job.last_k = n;
    q_job.fin    = in_item.final_byte;
    case (n)
      2'd3:    q_job.group = {held_r, in_item.data_byte};
      2'd2:    q_job.group = {held_r[7:0], in_item.data_byte, 8'd0};
      default: q_job.group = {in_item.data_byte, 16'd0};
    endcase
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (emit) begin
      held_nxt = 16'd0;
      cnt_nxt  = 2'd0;
    end else if (accept) begin
      held_nxt = {held_r[7:0], in_item.data_byte};
      cnt_nxt  = n;
    end
  end

  assign q_push  = emit;
  assign in_full = q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'd0;
      cnt_r  <= 2'd0;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* hdl/b64u_queue.sv */
// ----------------------------------------------------------------------------
// b64u_queue
// Short job queue between the byte collector and the character sender.
// ----------------------------------------------------------------------------
module b64u_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64u_pkg::job_t      wr_job,
  input  logic                pop,
  output b64u_pkg::job_t      rd_job,
  output b64u_pkg::q_status_t stat
);

  b64u_pkg::job_t                 slot_r [b64u_pkg::QDEPTH];
  logic [b64u_pkg::QAW-1:0]       wp_r, wp_nxt;
  logic [b64u_pkg::QAW-1:0]       rp_r, rp_nxt;
  logic [b64u_pkg::QCW-1:0]       cnt_r, cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  function automatic logic [b64u_pkg::QAW-1:0] bump(input logic [b64u_pkg::QAW-1:0] p);
    if (p == b64u_pkg::QAW'(b64u_pkg::QDEPTH - 1)) bump = '0;
    else bump = p + b64u_pkg::QAW'(1);
  endfunction

  always_comb begin
    stat.full  = (cnt_r == b64u_pkg::QCW'(b64u_pkg::QDEPTH));
    stat.empty = (cnt_r == '0);
    do_push    = push & ~stat.full;
    do_pop     = pop & ~stat.empty;
    wp_nxt     = do_push ? bump(wp_r) : wp_r;
    rp_nxt     = do_pop ? bump(rp_r) : rp_r;
    cnt_nxt    = cnt_r;
    if (do_push & ~do_pop) cnt_nxt = cnt_r + b64u_pkg::QCW'(1);
    else if (do_pop & ~do_push) cnt_nxt = cnt_r - b64u_pkg::QCW'(1);
  end

  assign rd_job = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/b64u_back.sv */
// ----------------------------------------------------------------------------
// b64u_back
// Walks the 6-bit fields of the head job and sends one character per cycle while the output register is free.
// ----------------------------------------------------------------------------
module b64u_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b64u_pkg::job_t       q_job,
  input  b64u_pkg::q_status_t  q_stat,
  output logic                 q_pop,
  input  logic                 out_pop,
  output b64u_pkg::out_item_t  out_item,
  output logic                 out_empty
);

  logic [1:0]          k_r, k_nxt;
  logic                vld_r, vld_nxt;
  b64u_pkg::out_item_t item_r, item_nxt;
  logic [5:0]          idx;
  logic                last;
  logic                load;

  always_comb begin
    case (k_r)
      2'd0:    idx = q_job.group[23:18];
      2'd1:    idx = q_job.group[17:12];
      2'd2:    idx = q_job.group[11:6];
      default: idx = q_job.group[5:0];
    endcase
    last  = (k_r == q_job.last_k);
    // output register frees up when empty or being drained this cycle
    load  = ~q_stat.empty & (~vld_r | out_pop);
    q_pop = load & last;

    item_nxt.code_char   = b64u_pkg::char_of(idx);
    item_nxt.run_end     = last;
    item_nxt.message_end = last & q_job.fin;

    k_nxt = k_r;
    if (load) k_nxt = last ? 2'd0 : k_r + 2'd1;

    vld_nxt = vld_r;
    if (load) vld_nxt = 1'b1;
    else if (out_pop) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      k_r   <= k_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_item  = item_r;
  assign out_empty = ~vld_r;

endmodule

/* hdl/base64_encoder_unpadded_core.sv */
// ----------------------------------------------------------------------------
// base64_encoder_unpadded_core
// Byte-serial unpadded base64 encoder, alphabet 0-9 a-z A-Z - _.
// ----------------------------------------------------------------------------
// Bytes go in through a queue-style port (push/full), one per cycle while
// full is low. A collector holds up to two bytes; the third byte of a group,
// or a byte flagged final, turns into a job of two to four characters in a
// two-entry queue. The sender drains that queue into an output register
// read with pop/empty, one character per cycle while that register is free
// or being popped. A full group gives four characters, so the character
// port, not the byte port, bounds the sustained rate. The first character
// of a job passes from the queue slot through the output register to the
// output ports. run_end marks the last character caused by a byte;
// message_end marks the last one of a message. No padding is emitted.
module base64_encoder_unpadded_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  b64u_pkg::in_item_t  in_item,
  output logic                in_full,
  input  logic                out_pop,
  output b64u_pkg::out_item_t out_item,
  output logic                out_empty
);

  b64u_pkg::q_status_t q_stat;
  b64u_pkg::job_t      wr_job;
  b64u_pkg::job_t      rd_job;
  logic                q_push;
  logic                q_pop;

  b64u_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_job   (wr_job)
  );

  b64u_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .pop    (q_pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (rd_job),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .out_empty (out_empty)
  );

endmodule

/* hdl/b64u_checker.sv */
// ----------------------------------------------------------------------------
// b64u_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_encoder_unpadded_core_defines.svh"

module b64u_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_pop,
  input b64u_pkg::out_item_t out_item,
  input logic                out_empty
);

  `B64U_CHECK_RST(a_rst_out_empty, !rst_n |=> out_empty, "output not empty after reset")

  `B64U_CHECK_RST(a_rst_in_open, !rst_n |=> !in_full, "input full after reset")

  `B64U_CHECK(a_msg_end_run_end, !out_empty |-> (!out_item.message_end || out_item.run_end), "message_end without run_end")

  `B64U_CHECK(a_hold_stalled, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)), "stalled transfer changed")

endmodule

bind base64_encoder_unpadded_core b64u_checker u_b64u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_item  (out_item),
  .out_empty (out_empty)
);

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for base64_encoder_unpadded_core: feeds byte messages through
// the push/full port, predicts the character stream, and checks every popped
// character against it, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [511:0] ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-_";

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  b64u_pkg::in_item_t  in_item = '0;
  logic                in_full;
  logic                out_pop = 1'b0;
  b64u_pkg::out_item_t out_item;
  logic                out_empty;

  b64u_pkg::in_item_t  pending_bytes[$];
  b64u_pkg::out_item_t expected_chars[$];
  logic [15:0] held_bytes = '0;
  logic [1:0]  held_count = '0;
  int unsigned bytes_total = 0;
  int unsigned bytes_sent = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned pop_gap = 0;
  bit          send_burst = 1'b0;
  bit          pop_burst = 1'b0;

  base64_encoder_unpadded_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .out_empty (out_empty)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int unsigned idle_cycles(input bit burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void queue_byte(input logic [7:0] data, input logic fin);
    b64u_pkg::in_item_t it;
    it.data_byte  = data;
    it.final_byte = fin;
    pending_bytes.push_back(it);
  endfunction

  // Predict the characters caused by one accepted byte.
  function automatic void encode_byte(input b64u_pkg::in_item_t it);
    logic [23:0]         grp;
    logic [5:0]          idx;
    b64u_pkg::out_item_t ch;
    int unsigned         n;
    int unsigned         nchars;
    n = ((held_count > 2'd2) ? 2 : int'(held_count)) + 1;
    if (n < 3 && !it.final_byte) begin
      held_bytes = {held_bytes[7:0], it.data_byte};
      held_count = n[1:0];
    end else begin
      if (n == 3)
        grp = {held_bytes, it.data_byte};
      else if (n == 2)
        grp = {held_bytes[7:0], it.data_byte, 8'h00};
      else
        grp = {it.data_byte, 16'h0000};
      nchars = n + 1;
      for (int k = 0; k < nchars; k++) begin
        idx = grp[18 - 6 * k +: 6];
        ch.code_char   = ALPHABET[8 * (63 - int'(idx)) +: 8];
        ch.run_end     = (k == nchars - 1);
        ch.message_end = (k == nchars - 1) && it.final_byte;
        expected_chars.push_back(ch);
      end
      held_bytes = '0;
      held_count = '0;
    end
  endfunction

  // Byte driver
  always @(posedge clk) begin : driver
    int unsigned w;
    if (!rst_n) begin
      in_push  <= 1'b0;
      send_gap <= 0;
    end else if (in_push && !in_full) begin
      encode_byte(in_item);
      bytes_sent++;
      if ($urandom_range(0, 29) == 0)
        send_burst = !send_burst;
      w = idle_cycles(send_burst);
      if (w == 0 && pending_bytes.size() > 0) begin
        in_item <= pending_bytes.pop_front();
      end else begin
        in_push  <= 1'b0;
        send_gap <= (w > 0) ? w - 1 : 0;
      end
    end else if (!in_push) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_bytes.size() > 0) begin
        in_item <= pending_bytes.pop_front();
        in_push <= 1'b1;
      end
    end
  end

  // Character monitor
  always @(posedge clk) begin : monitor
    int unsigned         w;
    b64u_pkg::out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap <= 0;
    end else if (out_pop && !out_empty) begin
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected char: expected none, actual char=%h run_end=%b msg_end=%b",
                 $time, out_item.code_char, out_item.run_end, out_item.message_end);
      end else begin
        want = expected_chars.pop_front();
        if (out_item.code_char !== want.code_char || out_item.run_end !== want.run_end ||
            out_item.message_end !== want.message_end) begin
          errors++;
          $display("%0t: char mismatch: expected char=%h run_end=%b msg_end=%b, actual char=%h run_end=%b msg_end=%b",
                   $time, want.code_char, want.run_end, want.message_end,
                   out_item.code_char, out_item.run_end, out_item.message_end);
        end
      end
      if ($urandom_range(0, 29) == 0)
        pop_burst = !pop_burst;
      w = idle_cycles(pop_burst);
      if (w > 0) begin
        out_pop <= 1'b0;
        pop_gap <= w - 1;
      end
    end else if (!out_pop) begin
      if (pop_gap > 0)
        pop_gap <= pop_gap - 1;
      else
        out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    logic [7:0]  data;

    // single leftover byte, both extremes
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b1);
    // two leftover bytes
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b1);
    // full group that ends the message
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b1);
    // full group mid-message, then one leftover
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h80, 1'b1);
    // group of all '-' characters
    queue_byte(8'hfb, 1'b0);
    queue_byte(8'hef, 1'b0);
    queue_byte(8'hbe, 1'b1);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'haa, 1'b1);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b1);

    // random messages, always closed with a final byte
    while (pending_bytes.size() < 18 + RANDOM_ITEMS) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          data = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else
          data = 8'($urandom_range(0, 255));
        queue_byte(data, i == len - 1);
      end
    end
    bytes_total = pending_bytes.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent < bytes_total || expected_chars.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_chars.size() > 0) begin
      errors++;
      $display("%0t: %0d expected chars never arrived", $time, expected_chars.size());
    end
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/b64u_pkg.sv
hdl/b64u_front.sv
hdl/b64u_queue.sv
hdl/b64u_back.sv
hdl/base64_encoder_unpadded_core.sv
hdl/b64u_checker.sv
test/tb.sv
